@@ sv/bpuf_pkg.sv @@
// shared types, constants and helper functions of the bracket pair ungap filter
package bpuf_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int STK_W   = ADDR_W + 2;
   localparam int SPAN_W  = 4;

   localparam logic [SPAN_W-1:0] SPAN_RESET = 4'd4;

   localparam logic [7:0] CH_GAP = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNCLOSED = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] seq_char;
      logic [7:0] struct_char;
      logic       last_column;
      logic [9:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic [10:0] ungapped_length;
      logic [1:0]  status;
      logic        is_read_reply;
   } rsp_type;

   // commands from controller to datapath
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ,
      CMD_REPLY,
      CMD_P1_INIT,
      CMD_FETCH,
      CMD_PUSH,
      CMD_POP,
      CMD_SEQ_J,
      CMD_NEXT,
      CMD_MARK_I,
      CMD_MARK_I_NEXT,
      CMD_MARK_J_NEXT,
      CMD_P1_END,
      CMD_UG_FETCH,
      CMD_UG_STORE,
      CMD_UG_END,
      CMD_FINISH
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic at_end;
      logic is_open;
      logic can_pop;
      logic pair_ok;
      logic gap_i;
      logic gap_j;
      logic too_close;
   } stat_type;

   // {valid, kind} of an opening bracket
   function automatic logic [2:0] open_code(input logic [7:0] c);
      case (c)
         8'h28:   open_code = 3'b100;
         8'h3C:   open_code = 3'b101;
         8'h5B:   open_code = 3'b110;
         8'h7B:   open_code = 3'b111;
         default: open_code = 3'b000;
      endcase
   endfunction

   // {valid, kind} of a closing bracket
   function automatic logic [2:0] close_code(input logic [7:0] c);
      case (c)
         8'h29:   close_code = 3'b100;
         8'h3E:   close_code = 3'b101;
         8'h5D:   close_code = 3'b110;
         8'h7D:   close_code = 3'b111;
         default: close_code = 3'b000;
      endcase
   endfunction

   // watson-crick and wobble pairs, upper case only
   function automatic logic bases_pair(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] ab;
      ab = {a, b};
      case (ab)
         {8'h41, 8'h54}, {8'h54, 8'h41},
         {8'h43, 8'h47}, {8'h47, 8'h43},
         {8'h41, 8'h55}, {8'h55, 8'h41},
         {8'h47, 8'h55}, {8'h55, 8'h47}: bases_pair = 1'b1;
         default:                        bases_pair = 1'b0;
      endcase
   endfunction

endpackage

@@ sv/bpuf_ctrl.sv @@
// controller state machine sequencing load, read, both matching passes and gap removal
module bpuf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_mode,
   input  logic               req_last,
   input  bpuf_pkg::stat_type stat,
   output bpuf_pkg::cmd_type  cmd,
   output logic               busy
);
   import bpuf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ_WAIT, ST_P1_START, ST_P1_CHK, ST_P1_DEC, ST_P1_SEQJ,
      ST_P1_CMP, ST_P1_WJ, ST_UG_CHK, ST_UG_WR, ST_P2_CHK, ST_P2_DEC,
      ST_P2_J, ST_P2_WJ
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode) begin
                  cmd      = CMD_READ;
                  state_in = ST_READ_WAIT;
               end else begin
                  cmd = CMD_LOAD;
                  if (req_last) state_in = ST_P1_START;
               end
            end
         end
         ST_READ_WAIT: begin
            cmd      = CMD_REPLY;
            state_in = ST_IDLE;
         end
         ST_P1_START: begin
            cmd      = CMD_P1_INIT;
            state_in = ST_P1_CHK;
         end
         ST_P1_CHK: begin
            if (stat.at_end) begin
               cmd      = CMD_P1_END;
               state_in = ST_UG_CHK;
            end else begin
               cmd      = CMD_FETCH;
               state_in = ST_P1_DEC;
            end
         end
         ST_P1_DEC: begin
            if (stat.is_open) begin
               cmd      = CMD_PUSH;
               state_in = ST_P1_CHK;
            end else if (stat.can_pop) begin
               cmd      = CMD_POP;
               state_in = ST_P1_SEQJ;
            end else begin
               cmd      = CMD_NEXT;
               state_in = ST_P1_CHK;
            end
         end
         ST_P1_SEQJ: begin
            cmd      = CMD_SEQ_J;
            state_in = ST_P1_CMP;
         end
         ST_P1_CMP: begin
            state_in = ST_P1_CHK;
            if (stat.pair_ok) begin
               cmd = CMD_NEXT;
            end else if (stat.gap_i) begin
               cmd = CMD_MARK_J_NEXT;
            end else if (stat.gap_j) begin
               cmd = CMD_MARK_I_NEXT;
            end else begin
               cmd      = CMD_MARK_I;
               state_in = ST_P1_WJ;
            end
         end
         ST_P1_WJ: begin
            cmd      = CMD_MARK_J_NEXT;
            state_in = ST_P1_CHK;
         end
         ST_UG_CHK: begin
            if (stat.at_end) begin
               cmd      = CMD_UG_END;
               state_in = ST_P2_CHK;
            end else begin
               cmd      = CMD_UG_FETCH;
               state_in = ST_UG_WR;
            end
         end
         ST_UG_WR: begin
            cmd      = CMD_UG_STORE;
            state_in = ST_UG_CHK;
         end
         ST_P2_CHK: begin
            if (stat.at_end) begin
               cmd      = CMD_FINISH;
               state_in = ST_IDLE;
            end else begin
               cmd      = CMD_FETCH;
               state_in = ST_P2_DEC;
            end
         end
         ST_P2_DEC: begin
            if (stat.is_open) begin
               cmd      = CMD_PUSH;
               state_in = ST_P2_CHK;
            end else if (stat.can_pop) begin
               cmd      = CMD_POP;
               state_in = ST_P2_J;
            end else begin
               cmd      = CMD_NEXT;
               state_in = ST_P2_CHK;
            end
         end
         ST_P2_J: begin
            if (stat.too_close) begin
               cmd      = CMD_MARK_I;
               state_in = ST_P2_WJ;
            end else begin
               cmd      = CMD_NEXT;
               state_in = ST_P2_CHK;
            end
         end
         ST_P2_WJ: begin
            cmd      = CMD_MARK_J_NEXT;
            state_in = ST_P2_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

@@ sv/bpuf_datapath.sv @@
// stores, stacks, counters and result register of the filter
module bpuf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bpuf_pkg::cmd_type             cmd,
   input  bpuf_pkg::req_type             req,
   input  logic                          csr_we,
   input  logic [bpuf_pkg::SPAN_W-1:0]   csr_wdata,
   output bpuf_pkg::stat_type            stat,
   output logic                          rsp_valid,
   output bpuf_pkg::rsp_type             rsp
);
   import bpuf_pkg::*;

   logic [7:0]        seq_mem [MAX_LEN];
   logic [7:0]        str_mem [MAX_LEN];
   logic [7:0]        ung_mem [MAX_LEN];
   logic [ADDR_W-1:0] stk_mem [4*MAX_LEN];

   logic [7:0]        seq_rd_ff, str_rd_ff, ung_rd_ff, seqi_ff;
   logic [ADDR_W-1:0] stk_rd_ff, j_ff;
   logic [CNT_W-1:0]  col_cnt_ff, len_ff, idx_ff, m_ff;
   logic [CNT_W-1:0]  sp_ff [4];
   logic [SPAN_W-1:0] span_ff;
   logic              ovf_ff, unclosed_ff, pass2_ff, hit_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [7:0]        cur_ch;
   logic [2:0]        oc, cc;
   logic [1:0]        kind;
   logic [CNT_W-1:0]  sp_sel, limit;
   logic [ADDR_W-1:0] idx_a, pair_dist;
   logic              room, mark_i, mark_j, step, any_open;

   // decode of the current character
   assign cur_ch    = pass2_ff ? ung_rd_ff : str_rd_ff;
   assign oc        = open_code(cur_ch);
   assign cc        = close_code(cur_ch);
   assign kind      = oc[2] ? oc[1:0] : cc[1:0];
   assign sp_sel    = sp_ff[kind];
   assign limit     = pass2_ff ? len_ff : col_cnt_ff;
   assign idx_a     = idx_ff[ADDR_W-1:0];
   assign pair_dist = idx_a - stk_rd_ff;
   assign room      = (col_cnt_ff < CNT_W'(MAX_LEN));
   assign mark_i    = (cmd == CMD_MARK_I) || (cmd == CMD_MARK_I_NEXT);
   assign mark_j    = (cmd == CMD_MARK_J_NEXT);
   assign step      = (cmd == CMD_PUSH) || (cmd == CMD_NEXT) || (cmd == CMD_MARK_I_NEXT)
                      || mark_j || (cmd == CMD_UG_STORE);
   assign any_open  = (sp_ff[0] != '0) || (sp_ff[1] != '0) || (sp_ff[2] != '0)
                      || (sp_ff[3] != '0);

   // status toward the controller
   always_comb begin
      stat.at_end    = (idx_ff == limit);
      stat.is_open   = oc[2];
      stat.can_pop   = cc[2] && (sp_ff[cc[1:0]] != '0);
      stat.pair_ok   = bases_pair(seqi_ff, seq_rd_ff);
      stat.gap_i     = (seqi_ff == CH_GAP);
      stat.gap_j     = (seq_rd_ff == CH_GAP);
      stat.too_close = (pair_dist < ADDR_W'(span_ff));
   end

   // sequence store
   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD && room) seq_mem[col_cnt_ff[ADDR_W-1:0]] <= req.seq_char;
      if (cmd == CMD_SEQ_J) begin
         seq_rd_ff <= seq_mem[stk_rd_ff];
      end else if (cmd == CMD_FETCH || cmd == CMD_UG_FETCH) begin
         seq_rd_ff <= seq_mem[idx_a];
      end
   end

   // structure store, edited in the first pass
   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD && room) begin
         str_mem[col_cnt_ff[ADDR_W-1:0]] <= req.struct_char;
      end else if (!pass2_ff && mark_i) begin
         str_mem[idx_a] <= CH_DOT;
      end else if (!pass2_ff && mark_j) begin
         str_mem[j_ff] <= CH_DOT;
      end
      if (cmd == CMD_FETCH || cmd == CMD_UG_FETCH) str_rd_ff <= str_mem[idx_a];
   end

   // ungapped store, filled by gap removal and edited in the second pass
   always_ff @(posedge clock) begin
      if (cmd == CMD_UG_STORE && seq_rd_ff != CH_GAP) begin
         ung_mem[m_ff[ADDR_W-1:0]] <= str_rd_ff;
      end else if (pass2_ff && mark_i) begin
         ung_mem[idx_a] <= CH_DOT;
      end else if (pass2_ff && mark_j) begin
         ung_mem[j_ff] <= CH_DOT;
      end
      if (cmd == CMD_READ) begin
         ung_rd_ff <= ung_mem[ADDR_W'(req.read_index)];
      end else if (cmd == CMD_FETCH) begin
         ung_rd_ff <= ung_mem[idx_a];
      end
   end

   // opener stacks, one region per bracket kind
   always_ff @(posedge clock) begin
      if (cmd == CMD_PUSH) stk_mem[{kind, sp_sel[ADDR_W-1:0]}] <= idx_a;
      if (cmd == CMD_POP) begin
         stk_rd_ff <= stk_mem[{kind, ADDR_W'(sp_sel - 1'b1)}];
      end
   end

   // latched pair operands and read hit flag
   always_ff @(posedge clock) begin
      if (cmd == CMD_POP) seqi_ff <= seq_rd_ff;
      if (cmd == CMD_SEQ_J || cmd == CMD_MARK_I) j_ff <= stk_rd_ff;
      if (cmd == CMD_READ) hit_ff <= (CNT_W'(req.read_index) < len_ff);
   end

   // counters, stack pointers and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         len_ff      <= '0;
         idx_ff      <= '0;
         m_ff        <= '0;
         ovf_ff      <= 1'b0;
         unclosed_ff <= 1'b0;
         pass2_ff    <= 1'b0;
         span_ff     <= SPAN_RESET;
         for (int k = 0; k < 4; k++) sp_ff[k] <= '0;
      end else begin
         if (csr_we) span_ff <= csr_wdata;
         if (step) idx_ff <= idx_ff + 1'b1;
         case (cmd)
            CMD_LOAD: begin
               if (room) col_cnt_ff <= col_cnt_ff + 1'b1;
               else      ovf_ff     <= 1'b1;
            end
            CMD_P1_INIT: begin
               idx_ff   <= '0;
               pass2_ff <= 1'b0;
               for (int k = 0; k < 4; k++) sp_ff[k] <= '0;
            end
            CMD_PUSH: sp_ff[kind] <= sp_sel + 1'b1;
            CMD_POP:  sp_ff[kind] <= sp_sel - 1'b1;
            CMD_P1_END: begin
               unclosed_ff <= any_open;
               idx_ff      <= '0;
               m_ff        <= '0;
            end
            CMD_UG_STORE: begin
               if (seq_rd_ff != CH_GAP) m_ff <= m_ff + 1'b1;
            end
            CMD_UG_END: begin
               len_ff   <= m_ff;
               idx_ff   <= '0;
               pass2_ff <= 1'b1;
               for (int k = 0; k < 4; k++) sp_ff[k] <= '0;
            end
            CMD_FINISH: begin
               col_cnt_ff <= '0;
               ovf_ff     <= 1'b0;
               pass2_ff   <= 1'b0;
               for (int k = 0; k < 4; k++) sp_ff[k] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd == CMD_REPLY) || (cmd == CMD_FINISH);
      end
      if (cmd == CMD_REPLY) begin
         rsp_ff.out_char        <= hit_ff ? ung_rd_ff : 8'd0;
         rsp_ff.ungapped_length <= 11'(len_ff);
         rsp_ff.status          <= STATUS_OK;
         rsp_ff.is_read_reply   <= 1'b1;
      end else if (cmd == CMD_FINISH) begin
         rsp_ff.out_char        <= 8'd0;
         rsp_ff.ungapped_length <= 11'(len_ff);
         rsp_ff.status          <= ovf_ff ? STATUS_OVERFLOW
                                  : (unclosed_ff ? STATUS_UNCLOSED : STATUS_OK);
         rsp_ff.is_read_reply   <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sv/bracket_pair_ungap_filter_core.sv @@
// top level of the bracket pair ungap filter
//
// channel   ports                     handshake
// request   req_data                  start high while busy low
// result    rsp_data                  rsp_valid high for one cycle
// config    csr_we, csr_wdata         csr_we high, no wait
//
// a column without last_column is stored at once and the block stays idle for
// the next column; a read fetches the character, then replies from a wait state,
// and the reply is registered onto the result ports; a last column is stored and
// then runs the first pass, gap removal over all columns and the second pass over
// the ungapped columns; the completion report follows in the next cycle
// each step is bounded by the single-port column, ungapped and stack memories
// reset is synchronous and clears control state only; stores need no clear
// the receiver cannot stall, so results are never held
module bracket_pair_ungap_filter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  bpuf_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output bpuf_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [bpuf_pkg::SPAN_W-1:0]  csr_wdata
);
   import bpuf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   bpuf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .req_last (req_data.last_column),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // storage and arithmetic
   bpuf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

@@ sv/bpuf_checker.sv @@
// port-level checks of the filter and their binding to the top level
module bpuf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bpuf_pkg::req_type req_data,
   input logic              rsp_valid,
   input bpuf_pkg::rsp_type rsp_data
);
   import bpuf_pkg::*;

   // a result only shows once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // a read transaction is followed by a read reply on the result ports
   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode) |=> ##1 (rsp_valid && rsp_data.is_read_reply))
      else $error("read reply missing");

   // a read transaction holds off the next one by raising busy
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode) |=> busy)
      else $error("not busy after read");

   // read replies carry ok status
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_read_reply) |-> (rsp_data.status == STATUS_OK))
      else $error("bad read status");

   // completion reports carry no character
   a_done_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_read_reply) |-> (rsp_data.out_char == 8'd0))
      else $error("completion with character");

endmodule

bind bracket_pair_ungap_filter_core bpuf_checker u_bpuf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
